// ===== rtl/best_fit_group_allocator_unit_assert.svh =====
// Assertion macros used by the allocator table engine RTL.
// Every check is sampled on the rising clock edge and is switched off while reset is low.
`ifndef BEST_FIT_GROUP_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_GROUP_ALLOCATOR_UNIT_ASSERT_SVH

// A condition that must hold at every edge.
`define BFGA_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// When the first condition holds, the second must hold at the same edge.
`define BFGA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the first condition holds, the second must hold at the next edge.
`define BFGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bfga_pkg.sv =====
package bfga_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int BLK_W   = 19;
    localparam int START_W = 10;
    localparam int GRP_W   = 11;
    localparam int BPG_W   = 9;
    localparam int STAT_W  = 2;

    // Pool size in groups; one chunk covers it after reset or clear
    localparam logic [GRP_W-1:0] POOL_GROUPS = 11'd1024;

    // Defaults for the top-level parameters
    localparam int MAX_CHUNKS_DEF = 16;
    localparam int JOB_DEPTH_DEF  = 2;
    localparam int RES_DEPTH_DEF  = 2;

    // Configuration register map: word index taken from paddr[2]
    localparam int  ADDR_W    = 3;
    localparam logic REG_BPG  = 1'b0;
    localparam logic [BPG_W-1:0] BPG_RESET = 9'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Classified command handed from the front end to the table engine
    typedef struct packed {
        t_cmd               cmd;
        logic [BLK_W-1:0]   need;
        logic [START_W-1:0] estart;
        logic [GRP_W-1:0]   egroups;
    } t_job;

    // One result item
    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] start;
        logic [GRP_W-1:0]   groups;
    } t_result;

endpackage

// ===== rtl/bfga_queue.sv =====
module bfga_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/bfga_front.sv =====
module bfga_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic [bfga_pkg::CMD_W-1:0]        i_command,
    input  logic [bfga_pkg::BLK_W-1:0]        i_block_count,
    input  logic [bfga_pkg::START_W-1:0]      i_entry_start,
    input  logic [bfga_pkg::GRP_W-1:0]        i_entry_groups,
    input  logic [bfga_pkg::BPG_W-1:0]        i_bpg,
    output logic                              o_job_push,
    output bfga_pkg::t_job                    o_job,
    input  logic                              i_job_full
);

    import bfga_pkg::*;

    localparam int STEP_W = $clog2(BLK_W);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_ROUND,
        F_PUSH
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [BLK_W-1:0]   r_dvd;
    logic [BPG_W-1:0]   r_rem;
    logic [BPG_W-1:0]   r_unit;
    logic [STEP_W-1:0]  r_step;
    logic [BLK_W-1:0]   r_need;
    logic [START_W-1:0] r_estart;
    logic [GRP_W-1:0]   r_egroups;

    logic [BPG_W:0]     rem_sh;
    logic [BPG_W:0]     rem_nx;
    logic               q_bit;

    // One restoring division step: remainder shifts in the next dividend bit
    always_comb begin
        rem_sh = {r_rem, r_dvd[BLK_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_unit});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_unit}) : rem_sh;
    end

    assign o_full     = (r_state != F_IDLE);
    assign o_job_push = (r_state == F_PUSH) && !i_job_full;

    always_comb begin
        o_job.cmd     = r_cmd;
        o_job.need    = r_need;
        o_job.estart  = r_estart;
        o_job.egroups = r_egroups;
    end

    // Sequencer: accept, divide for an allocate, round up, hand over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_cmd     <= t_cmd'(i_command);
                        r_estart  <= i_entry_start;
                        r_egroups <= i_entry_groups;
                        // a group size of zero counts as one
                        r_unit    <= (i_bpg == '0) ? BPG_W'(1) : i_bpg;
                        r_dvd     <= i_block_count;
                        r_rem     <= '0;
                        r_step    <= '0;
                        r_need    <= '0;
                        r_state   <= (t_cmd'(i_command) == CMD_ALLOC) ? F_DIV : F_PUSH;
                    end
                end
                F_DIV: begin
                    r_rem <= rem_nx[BPG_W-1:0];
                    r_dvd <= {r_dvd[BLK_W-2:0], q_bit};
                    if (r_step == STEP_W'(BLK_W - 1)) begin
                        r_state <= F_ROUND;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                F_ROUND: begin
                    // quotient plus one where a remainder is left
                    r_need  <= r_dvd + BLK_W'(r_rem != '0);
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_job_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/bfga_back.sv =====
`include "best_fit_group_allocator_unit_assert.svh"

module bfga_back #(
    parameter int MAX_CHUNKS = bfga_pkg::MAX_CHUNKS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfga_pkg::t_job    i_job,
    input  logic              i_job_empty,
    output logic              o_job_pop,
    output logic              o_res_push,
    output bfga_pkg::t_result o_res,
    input  logic              i_res_full
);

    import bfga_pkg::*;

    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = $clog2(MAX_CHUNKS + 1);
    localparam int EW = START_W + GRP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SHIFT
    } t_state;

    // Chunk table: start in the upper bits, size in the lower
    logic [EW-1:0]      r_mem [MAX_CHUNKS];
    logic [EW-1:0]      r_rd_data;
    logic               r_rd0;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic               r_e0_def;
    logic [BLK_W-1:0]   r_need;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_best;
    logic [START_W-1:0] r_best_start;
    logic [GRP_W-1:0]   r_best_groups;
    logic               r_found;
    logic [IW-1:0]      r_wr_ptr;
    logic               r_res_push;
    t_result            r_res;

    logic [IW-1:0]      rd_addr;
    logic               we;
    logic [IW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;
    logic [START_W-1:0] d_start;
    logic [GRP_W-1:0]   d_groups;
    logic               fits;
    logic               exact;
    logic               better;
    logic               scan_last;
    logic               best_last;
    logic               shift_last;
    logic               best_exact;

    assign o_res_push = r_res_push;
    assign o_res      = r_res;

    // Entry 0 reads as the whole pool until it is first written
    always_comb begin
        if (r_rd0 && r_e0_def) begin
            d_start  = '0;
            d_groups = POOL_GROUPS;
        end else begin
            d_start  = r_rd_data[EW-1:GRP_W];
            d_groups = r_rd_data[GRP_W-1:0];
        end
    end

    // Fit tests on the entry under scan
    always_comb begin
        fits       = (r_need <= BLK_W'(d_groups));
        exact      = (r_need == BLK_W'(d_groups));
        better     = fits && (!r_found || (d_groups < r_best_groups));
        scan_last  = (CW'(r_idx) + CW'(1) == r_count);
        best_last  = (CW'(r_best) + CW'(1) == r_count);
        shift_last = (CW'(r_wr_ptr) + CW'(2) == r_count);
        best_exact = (r_best_groups == r_need[GRP_W-1:0]);
    end

    // Take a job only with room for its result already settled
    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty && !i_res_full && !r_res_push;

    // Table read and write ports
    always_comb begin
        rd_addr = '0;
        we      = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (r_state)
            S_IDLE: begin
                if (o_job_pop && (i_job.cmd == CMD_APPEND) &&
                    (r_count != CW'(MAX_CHUNKS)) && (i_job.egroups != '0)) begin
                    we      = 1'b1;
                    wr_addr = r_count[IW-1:0];
                    wr_data = {i_job.estart, i_job.egroups};
                end
            end
            S_SCAN: begin
                rd_addr = r_idx + IW'(1);
            end
            S_APPLY: begin
                rd_addr = r_best + IW'(1);
                if (r_found && !best_exact) begin
                    // split: start moves past the grant, size shrinks by it
                    we      = 1'b1;
                    wr_addr = r_best;
                    wr_data = {r_best_start + r_need[START_W-1:0],
                               r_best_groups - r_need[GRP_W-1:0]};
                end
            end
            S_SHIFT: begin
                rd_addr = r_wr_ptr + IW'(2);
                we      = 1'b1;
                wr_addr = r_wr_ptr;
                wr_data = {d_start, d_groups};
            end
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd0     <= (rd_addr == '0);
    end

    // Table engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= CW'(1);
            r_e0_def   <= 1'b1;
            r_found    <= 1'b0;
            r_res_push <= 1'b0;
        end else begin
            r_res_push <= 1'b0;
            if (we && (wr_addr == '0)) begin
                r_e0_def <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_need <= i_job.need;
                        r_res  <= '{status: ST_DONE, start: '0, groups: '0};
                        unique case (i_job.cmd)
                            CMD_ALLOC: begin
                                if (r_count == '0) begin
                                    r_res.status <= ST_EMPTY;
                                    r_res_push   <= 1'b1;
                                end else if (i_job.need == '0) begin
                                    r_res.status <= ST_NOFIT;
                                    r_res_push   <= 1'b1;
                                end else begin
                                    r_idx   <= '0;
                                    r_found <= 1'b0;
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_APPEND: begin
                                r_res_push <= 1'b1;
                                if (r_count == CW'(MAX_CHUNKS)) begin
                                    r_res.status <= ST_FULL;
                                end else if (i_job.egroups == '0) begin
                                    r_res.status <= ST_NOFIT;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            CMD_CLEAR: begin
                                r_count    <= CW'(1);
                                r_e0_def   <= 1'b1;
                                r_res_push <= 1'b1;
                            end
                            CMD_NONE: begin
                                r_res_push <= 1'b1;
                            end
                            default: r_res_push <= 1'b1;
                        endcase
                    end
                end
                S_SCAN: begin
                    // exact fit stops the scan; otherwise keep smallest leftover
                    if (exact) begin
                        r_best        <= r_idx;
                        r_best_start  <= d_start;
                        r_best_groups <= d_groups;
                        r_found       <= 1'b1;
                        r_state       <= S_APPLY;
                    end else begin
                        if (better) begin
                            r_best        <= r_idx;
                            r_best_start  <= d_start;
                            r_best_groups <= d_groups;
                            r_found       <= 1'b1;
                        end
                        if (scan_last) begin
                            r_state <= S_APPLY;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_APPLY: begin
                    r_res_push <= 1'b1;
                    r_state    <= S_IDLE;
                    if (!r_found) begin
                        r_res.status <= ST_NOFIT;
                    end else begin
                        r_res.status <= ST_DONE;
                        r_res.start  <= r_best_start;
                        r_res.groups <= r_need[GRP_W-1:0];
                        if (best_exact) begin
                            if (best_last) begin
                                r_count <= r_count - CW'(1);
                            end else begin
                                r_wr_ptr <= r_best;
                                r_state  <= S_SHIFT;
                            end
                        end
                    end
                end
                S_SHIFT: begin
                    // close the gap one entry a cycle
                    if (shift_last) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_wr_ptr <= r_wr_ptr + IW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BFGA_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_CHUNKS), "chunk count over table depth")
    `BFGA_ASSERT_IMPL(a_res_room, i_clk, i_rst_n, r_res_push, !i_res_full, "result transfer into full queue")
    `BFGA_ASSERT_IMPL(a_shift_exact, i_clk, i_rst_n, r_state == S_SHIFT, r_found && best_exact, "gap closing without exact fit")
    `BFGA_ASSERT_IMPL(a_grant_fits, i_clk, i_rst_n, (r_state == S_APPLY) && r_found, r_need <= BLK_W'(r_best_groups), "chosen chunk smaller than request")
    `BFGA_ASSERT_NEXT(a_shift_count, i_clk, i_rst_n, (r_state == S_SHIFT) && shift_last, r_count == $past(r_count) - CW'(1), "chunk count not reduced after removal")

endmodule

// ===== rtl/best_fit_group_allocator_unit.sv =====
// Best-fit group allocator over a table of free chunks.
// Input channel: drive the command fields and raise push; a transfer happens
// on a rising edge with push high and full low. Results: while empty is low,
// the oldest result sits on o_status, o_granted_start and o_granted_groups;
// it is removed on a rising edge with pop high.
// Configuration: APB write to byte address 0 sets blocks_per_group (0 acts as 1).
// The front end takes one item at a time, divides the block count by the
// group size one quotient bit a cycle, rounds up, and posts a job; other
// commands skip the division. The table engine pops jobs: an allocate scans
// up to chunk_count entries, one a cycle, through the table memory read
// port, stopping at an exact fit, then applies the grant; an exact fit short
// of the last entry closes the gap, one entry a cycle, as the result is
// posted. The front end can accept a new item once its job is posted,
// while the engine still works on earlier jobs. Each result is registered
// in the engine and then passes through the result queue to the ports.
// Reset: one chunk covers the whole pool, both queues are empty and
// blocks_per_group is 1. No clearing pass is needed.
// A stalled receiver fills the RES_DEPTH-entry result queue, the engine then
// holds, the JOB_DEPTH-entry job queue fills and full stays high until pop.
module best_fit_group_allocator_unit #(
    parameter int MAX_CHUNKS = bfga_pkg::MAX_CHUNKS_DEF,
    parameter int JOB_DEPTH  = bfga_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH  = bfga_pkg::RES_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [bfga_pkg::CMD_W-1:0]        i_command,
    input  logic [bfga_pkg::BLK_W-1:0]        i_block_count,
    input  logic [bfga_pkg::START_W-1:0]      i_entry_start,
    input  logic [bfga_pkg::GRP_W-1:0]        i_entry_groups,
    output logic                              empty,
    input  logic                              pop,
    output logic [bfga_pkg::STAT_W-1:0]       o_status,
    output logic [bfga_pkg::START_W-1:0]      o_granted_start,
    output logic [bfga_pkg::GRP_W-1:0]        o_granted_groups,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfga_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    import bfga_pkg::*;

    logic [BPG_W-1:0]      r_bpg;
    logic                  job_push;
    t_job                  job_in;
    logic                  job_full;
    logic [$bits(t_job)-1:0] jobq_data;
    t_job                  job_out;
    logic                  job_empty;
    logic                  job_pop;
    logic                  res_push;
    t_result               res_in;
    logic                  res_full;
    logic [$bits(t_result)-1:0] resq_data;
    t_result               res_out;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BPG) ? {{(32 - BPG_W){1'b0}}, r_bpg} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpg <= BPG_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BPG)) begin
            r_bpg <= pwdata[BPG_W-1:0];
        end
    end

    // Front end: accept and classify
    bfga_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_block_count  (i_block_count),
        .i_entry_start  (i_entry_start),
        .i_entry_groups (i_entry_groups),
        .i_bpg          (r_bpg),
        .o_job_push     (job_push),
        .o_job          (job_in),
        .i_job_full     (job_full)
    );

    // Job queue between the two halves
    bfga_queue #(
        .DEPTH (JOB_DEPTH),
        .WIDTH ($bits(t_job))
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (jobq_data),
        .o_empty (job_empty)
    );

    assign job_out = t_job'(jobq_data);

    // Table engine
    bfga_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // Result queue facing the receiver
    bfga_queue #(
        .DEPTH (RES_DEPTH),
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (resq_data),
        .o_empty (empty)
    );

    assign res_out          = t_result'(resq_data);
    assign o_status         = res_out.status;
    assign o_granted_start  = res_out.start;
    assign o_granted_groups = res_out.groups;

endmodule
